// ===== sv/varint_string_deframer_top_defines.svh =====
// ----------------------------------------------------------------------------
// varint_string_deframer_top_defines.svh
// Assertion macros shared by the deframer's checker.
// ----------------------------------------------------------------------------
`ifndef VARINT_STRING_DEFRAMER_TOP_DEFINES_SVH
`define VARINT_STRING_DEFRAMER_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define VSD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define VSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vsd_pkg
// Types and constants of the varint and string deframer.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int VSD_MAX_VARINT_BYTES = 5;
    localparam int VSD_VALUE_GROUPS     = 5;
    localparam int VSD_LEN_W            = 15;
    localparam logic [VSD_LEN_W-1:0] VSD_MAX_LEN_RESET = 15'h7FFF;

    typedef enum logic [1:0] {
        EV_BUSY  = 2'd0,
        EV_VALUE = 2'd1,
        EV_BYTE  = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CLOSED    = 3'd1,
        ERR_TOO_LONG  = 3'd2,
        ERR_BAD_LEN   = 3'd3,
        ERR_CUT_SHORT = 3'd4
    } err_t;

    typedef enum logic {
        PH_VARINT  = 1'b0,
        PH_PAYLOAD = 1'b1
    } phase_t;

    typedef enum logic {
        CFG_FRAME_MODE = 1'b0,
        CFG_MAX_LENGTH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        event_t             event_res;
        logic signed [31:0] out_value;
        logic [7:0]         out_byte;
        logic               last;
        err_t               error_code;
    } out_t;

endpackage

// ===== sv/varint_string_deframer_top.sv =====
// ----------------------------------------------------------------------------
// varint_string_deframer_top
// Byte-serial decoder for base-128 varints and varint-prefixed strings.
// ----------------------------------------------------------------------------
// The input channel takes one stream byte per beat, or a stream-end marker.
// The output channel gives exactly one result beat per input beat: busy, a
// finished varint value, a payload byte (with last on the final one) or an
// error code. Each beat is decoded in the cycle it is accepted and its result
// is registered into the output register, or into the skid register when the
// output is stalled. It takes one beat per cycle while in_ready is high. The
// output register is backed by a skid register; input ready drops only when
// both hold a result, so a stalled receiver holds the input side off after two
// waiting results. cfg_we writes frame_mode or max_length with no handshake.
// Reset empties both result registers, returns the decoder to idle varint
// reading, and sets frame_mode to strings and max_length to 32767.
// ----------------------------------------------------------------------------
module varint_string_deframer_top
    import vsd_pkg::*;
#(
    parameter int MAX_VARINT_BYTES = VSD_MAX_VARINT_BYTES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_t                 out_data,
    input  logic                 cfg_we,
    input  cfg_idx_t             cfg_idx,
    input  logic [VSD_LEN_W-1:0] cfg_wdata
);

    localparam int GC_W = $clog2(MAX_VARINT_BYTES + 1);

    logic                 frame_mode_reg;
    logic [VSD_LEN_W-1:0] max_length_reg;

    phase_t               phase_reg, phase_next;
    logic [31:0]          acc_reg, acc_next;
    logic [GC_W-1:0]      gc_reg, gc_next;
    logic [VSD_LEN_W-1:0] left_reg, left_next;

    logic out_valid_reg, skid_valid_reg;
    out_t out_data_reg, skid_data_reg;
    out_t result;

    logic                 in_fire, out_fire;
    logic [31:0]          acc_merged;
    logic [38:0]          group_wide;
    logic [VSD_LEN_W-1:0] left_dec;
    logic                 too_long, cont, bad_len;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_fire  = out_valid_reg && out_ready;

    always_comb
    begin
        acc_merged = acc_reg;
        group_wide = '0;
        for (int k = 0; k < VSD_VALUE_GROUPS; k++)
        begin
            if (int'(gc_reg) == k)
            begin
                group_wide = 39'(in_data.data_byte[6:0]) << (7 * k);
                acc_merged = acc_reg | group_wide[31:0];
            end
        end
    end

    assign left_dec = left_reg - VSD_LEN_W'(1);
    assign too_long = (int'(gc_reg) == MAX_VARINT_BYTES);
    assign cont     = in_data.data_byte[7];
    assign bad_len  = acc_merged[31] || (acc_merged == 32'd0)
                      || (acc_merged > {17'd0, max_length_reg});

    always_comb
    begin
        phase_next = phase_reg;
        if (in_data.stream_end)
        begin
            phase_next = PH_VARINT;
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            if (left_dec == '0)
            begin
                phase_next = PH_VARINT;
            end
        end
        else if (!too_long && !cont && frame_mode_reg && !bad_len)
        begin
            phase_next = PH_PAYLOAD;
        end
    end

    always_comb
    begin
        acc_next  = '0;
        gc_next   = '0;
        left_next = '0;
        result    = '{event_res: EV_BUSY, out_value: '0, out_byte: '0, last: 1'b0,
                      error_code: ERR_NONE};
        if (in_data.stream_end)
        begin
            result.event_res  = EV_ERROR;
            result.error_code = (phase_reg == PH_PAYLOAD) ? ERR_CUT_SHORT : ERR_CLOSED;
        end
        else if (phase_reg == PH_PAYLOAD)
        begin
            left_next       = left_dec;
            result.event_res = EV_BYTE;
            result.out_byte  = in_data.data_byte;
            result.last      = (left_dec == '0);
        end
        else if (too_long)
        begin
            result.event_res  = EV_ERROR;
            result.error_code = ERR_TOO_LONG;
        end
        else if (cont)
        begin
            acc_next = acc_merged;
            gc_next  = gc_reg + GC_W'(1);
        end
        else if (!frame_mode_reg)
        begin
            result.event_res = EV_VALUE;
            result.out_value = acc_merged;
        end
        else if (bad_len)
        begin
            result.event_res  = EV_ERROR;
            result.error_code = ERR_BAD_LEN;
        end
        else
        begin
            left_next = acc_merged[VSD_LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_mode_reg <= 1'b1;
            max_length_reg <= VSD_MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_FRAME_MODE: frame_mode_reg <= cfg_wdata[0];
                CFG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                default:        frame_mode_reg <= frame_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VARINT;
            acc_reg   <= '0;
            gc_reg    <= '0;
            left_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            gc_reg    <= gc_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_data_reg <= result;
            end
            else
            begin
                out_data_reg <= result;
            end
        end
    end

endmodule

// ===== sv/vsd_checker.sv =====
// ----------------------------------------------------------------------------
// vsd_checker
// Port-level checks of the varint and string deframer.
// ----------------------------------------------------------------------------
`include "varint_string_deframer_top_defines.svh"

module vsd_checker
    import vsd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input in_t  in_data,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    `VSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "Result beat changed while stalled.")
    `VSD_ASSERT_SAME(a_err_code, clk, rst_n, out_valid,
        (out_data.event_res == EV_ERROR) == (out_data.error_code != ERR_NONE),
        "Error code does not match the error event.")
    `VSD_ASSERT_SAME(a_last_byte, clk, rst_n, out_valid && out_data.last,
        out_data.event_res == EV_BYTE, "Last is set on a beat that is not a payload byte.")
    `VSD_ASSERT_NEXT(a_end_error, clk, rst_n,
        in_valid && in_ready && in_data.stream_end && !out_valid,
        out_valid && out_data.event_res == EV_ERROR, "Stream end did not give an error beat.")

endmodule

bind varint_string_deframer_top vsd_checker u_vsd_checker (.*);
